// ----- hdl/convolutional_encoder_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CONVOLUTIONAL_ENCODER_CORE_ASSERT_SVH
`define CONVOLUTIONAL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("convolutional encoder check failed");

// Next-cycle implication.
`define CEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("convolutional encoder check failed");

`endif

// ----- hdl/cec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cec_pkg;

   localparam int STATE_W   = 8;
   localparam int GEN_W     = 9;
   localparam int GEN_REGS  = 5;
   localparam int CODED_W   = 5;
   localparam int K_W       = 5;
   localparam int K_REG_W   = 4;
   localparam int N_W       = 3;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ENCODE = 2'd0,
      OP_FLUSH  = 2'd1,
      OP_LOAD   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONSTRAINT = 3'd0,
      CSR_GEN_COUNT  = 3'd1,
      CSR_GEN_0      = 3'd2,
      CSR_GEN_1      = 3'd3,
      CSR_GEN_2      = 3'd4,
      CSR_GEN_3      = 3'd5,
      CSR_GEN_4      = 3'd6
   } csr_index_type;

   typedef logic [GEN_REGS-1:0][GEN_W-1:0] gen_array_type;

   typedef struct packed {
      logic [CODED_W-1:0] coded;
      logic [STATE_W-1:0] shifted;
      logic               state_err;
   } step_type;

   // True when value has a bit set at or above position k-1.
   function automatic logic out_of_range(input logic [STATE_W-1:0] value,
                                         input logic [K_W-1:0] k);
      logic err;
      err = 1'b0;
      for (int i = 0; i < STATE_W; i++) begin
         if (i >= int'(k) - 1 && value[i]) begin
            err = 1'b1;
         end
      end
      return err;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/convolutional_encoder_core.sv -----
// Rate 1/n convolutional encoder, K = 2..9, up to five generators. The core takes one
// request per clock while req_tready is high and returns one coded group per clock,
// while rsp_tready allows, through a result register. A flush request produces K-1
// zero-input groups and an encode request with tlast set produces its own group plus
// K-1 zero-input groups; the first group leaves in the cycle after acceptance and the
// flush counter drops req_tready while the remaining groups are produced; rsp_tready
// stalls also hold it low. Load requests and refused requests (error on tuser) return
// one result. Operation code 3 is taken and dropped.
// CSR writes are accepted in any cycle and must be issued while the core is idle.
`timescale 1ns / 1ps
`default_nettype none

module convolutional_encoder_core import cec_pkg::*; #(
   parameter int MAX_CONSTRAINT = 9,
   parameter int MAX_GENERATORS = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [15:0]          req_tdata,  // data_bit, new_state[7:0], zero pad
   input  wire logic                 req_tlast,  // flush_after
   input  wire logic [OP_W-1:0]      req_tuser,  // operation
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [15:0]          rsp_tdata,  // coded_bits[4:0], state_after[7:0], pad
   output      logic                 rsp_tlast,  // last
   output      logic                 rsp_tuser,  // error
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GEN_W-1:0]     csr_data
);

   localparam int CNT_W = 4;
   localparam logic [K_W-1:0] KMAX = K_W'(MAX_CONSTRAINT);
   localparam int NCAP_I = (MAX_GENERATORS < GEN_REGS) ? MAX_GENERATORS : GEN_REGS;
   localparam logic [N_W-1:0] NCAP = N_W'(NCAP_I);
   localparam int PAD_W = 16 - STATE_W - CODED_W;

   logic [K_REG_W-1:0] k_ff;
   logic [N_W-1:0]     n_ff;
   gen_array_type      gen_ff;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODED_W-1:0] rsp_coded_ff, rsp_coded_in;
   logic [STATE_W-1:0] rsp_state_ff, rsp_state_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [K_W-1:0]     k_eff;
   logic [N_W-1:0]     n_eff;
   logic               slot_free;
   logic               flushing;
   logic               accept;
   logic               step_bit;
   logic               load_err;
   op_type             op;
   logic               data_bit;
   logic [STATE_W-1:0] new_state;
   step_type           step;

   assign op        = op_type'(req_tuser);
   assign data_bit  = req_tdata[0];
   assign new_state = req_tdata[STATE_W:1];

   always_comb begin
      if (k_ff < K_REG_W'(2)) begin
         k_eff = K_W'(2);
      end else if (K_W'(k_ff) > KMAX) begin
         k_eff = KMAX;
      end else begin
         k_eff = K_W'(k_ff);
      end
   end

   always_comb begin
      if (n_ff == '0) begin
         n_eff = N_W'(1);
      end else if (n_ff > NCAP) begin
         n_eff = NCAP;
      end else begin
         n_eff = n_ff;
      end
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign flushing   = cnt_ff != '0;
   assign req_tready = !flushing && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign step_bit   = !flushing && op == OP_ENCODE && data_bit;
   assign load_err   = out_of_range(new_state, k_eff);

   cec_step u_step (
      .state    (state_ff),
      .data_bit (step_bit),
      .k        (k_eff),
      .n        (n_eff),
      .gens     (gen_ff),
      .step     (step)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_coded_in = rsp_coded_ff;
      rsp_state_in = rsp_state_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (flushing && slot_free) begin
         state_in     = step.shifted;
         cnt_in       = cnt_ff - CNT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_coded_in = step.coded;
         rsp_state_in = step.shifted;
         rsp_err_in   = 1'b0;
         rsp_last_in  = cnt_ff == CNT_W'(1);
      end else if (accept) begin
         case (op)
            OP_ENCODE, OP_FLUSH: begin
               rsp_valid_in = 1'b1;
               if (step.state_err) begin
                  rsp_coded_in = '0;
                  rsp_state_in = state_ff;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b1;
               end else begin
                  state_in     = step.shifted;
                  rsp_coded_in = step.coded;
                  rsp_state_in = step.shifted;
                  rsp_err_in   = 1'b0;
                  if (op == OP_FLUSH) begin
                     cnt_in      = CNT_W'(k_eff - K_W'(2));
                     rsp_last_in = k_eff == K_W'(2);
                  end else begin
                     cnt_in      = req_tlast ? CNT_W'(k_eff - K_W'(1)) : '0;
                     rsp_last_in = !req_tlast;
                  end
               end
            end
            OP_LOAD: begin
               rsp_valid_in = 1'b1;
               rsp_coded_in = '0;
               rsp_err_in   = load_err;
               rsp_last_in  = 1'b1;
               if (load_err) begin
                  rsp_state_in = state_ff;
               end else begin
                  state_in     = new_state;
                  rsp_state_in = new_state;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coded_ff <= rsp_coded_in;
      rsp_state_ff <= rsp_state_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= K_REG_W'(7);
         n_ff      <= N_W'(2);
         gen_ff[0] <= GEN_W'(9'o171);
         gen_ff[1] <= GEN_W'(9'o133);
         gen_ff[2] <= '0;
         gen_ff[3] <= '0;
         gen_ff[4] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONSTRAINT: k_ff      <= csr_data[K_REG_W-1:0];
            CSR_GEN_COUNT:  n_ff      <= csr_data[N_W-1:0];
            CSR_GEN_0:      gen_ff[0] <= csr_data;
            CSR_GEN_1:      gen_ff[1] <= csr_data;
            CSR_GEN_2:      gen_ff[2] <= csr_data;
            CSR_GEN_3:      gen_ff[3] <= csr_data;
            CSR_GEN_4:      gen_ff[4] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_state_ff, rsp_coded_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

// ----- hdl/cec_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cec_step import cec_pkg::*; (
   input  wire logic [STATE_W-1:0] state,
   input  wire logic               data_bit,
   input  wire logic [K_W-1:0]     k,
   input  wire logic [N_W-1:0]     n,
   input  wire gen_array_type      gens,
   output step_type                step
);

   logic [GEN_W-1:0] padded;
   logic [GEN_W-1:0] shift_reg;

   assign padded = GEN_W'(state);

   always_comb begin
      shift_reg = '0;
      for (int i = 0; i < GEN_W; i++) begin
         if (i < int'(k) - 1) begin
            shift_reg[i] = padded[i];
         end else if (i == int'(k) - 1) begin
            shift_reg[i] = data_bit;
         end
      end
   end

   always_comb begin
      step.coded   = '0;
      step.shifted = '0;
      for (int j = 0; j < CODED_W; j++) begin
         if (j < int'(n)) begin
            step.coded[j] = ^(shift_reg & gens[j]);
         end
      end
      for (int i = 0; i < STATE_W; i++) begin
         if (i == int'(k) - 2) begin
            step.shifted[i] = data_bit;
         end else if (i < int'(k) - 2) begin
            step.shifted[i] = padded[i+1];
         end
      end
      step.state_err = out_of_range(state, k);
   end

endmodule

`default_nettype wire

// ----- hdl/cec_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "convolutional_encoder_core_assert.svh"

module cec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   logic [17:0] rsp_word;

   assign rsp_word = {rsp_tuser, rsp_tlast, rsp_tdata};

   // Stalled result holds.
   `CEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word))

   // Refused request: single result, no coded bits.
   `CEC_ASSERT_NOW(a_err_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_tdata[4:0] == 5'd0)

   // Mid-flush: no new request taken, no error.
   `CEC_ASSERT_NOW(a_flush_block, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready && !rsp_tuser)

   // Reset empties the result register.
   `CEC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // No request taken while a stalled flush group waits.
   `CEC_ASSERT_NOW(a_no_take_mid, clock, reset, rsp_tvalid && !rsp_tlast && req_tvalid, !req_tready)

endmodule

bind convolutional_encoder_core cec_checker u_checker (.*);

`default_nettype wire

// ----- sim/convolutional_encoder_core_test.sv -----
`timescale 1ns / 1ps

module convolutional_encoder_core_test;
   import cec_pkg::*;

   localparam int MAX_K = 9;
   localparam int MAX_N = 5;
   localparam int QUIET_CYCLES = 16;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [CODED_W-1:0] coded;
      logic               fault;
      logic               last;
      logic [STATE_W-1:0] state;
   } group_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic               din;
      logic               fl;
      logic [STATE_W-1:0] ns;
   } request_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;    // data_bit, new_state[7:0], zero pad
   logic                 req_tlast = 1'b0;  // flush_after
   logic [OP_W-1:0]      req_tuser = OP_ENCODE; // operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // coded_bits[4:0], state_after[7:0], pad
   logic                 rsp_tlast;         // last
   logic                 rsp_tuser;         // error
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GEN_W-1:0]     csr_data = '0;

   convolutional_encoder_core #(
      .MAX_CONSTRAINT(MAX_K),
      .MAX_GENERATORS(MAX_N)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // encoder shadow: configuration and trellis state
   logic [K_REG_W-1:0] cfg_k = 4'd7;
   logic [N_W-1:0]     cfg_n = 3'd2;
   logic [GEN_W-1:0]   gens [GEN_REGS] = '{9'o171, 9'o133, 9'd0, 9'd0, 9'd0};
   logic [STATE_W-1:0] enc_state = '0;

   request_type req_backlog [$];
   group_type   coded_groups_due [$];
   request_type nxt;
   group_type   got;
   group_type   want;

   logic req_taken = 1'b0;
   logic steady = 1'b0;
   int   mismatches = 0;
   int   requests_done = 0;
   int   groups_seen = 0;
   int   refused_seen = 0;
   int   csr_writes = 0;
   int   settings_run = 0;

   function automatic int eff_length();
      if (cfg_k < 2) return 2;
      if (cfg_k > MAX_K) return MAX_K;
      return int'(cfg_k);
   endfunction

   function automatic int eff_width();
      int cap;
      cap = (MAX_N > GEN_REGS) ? GEN_REGS : MAX_N;
      if (cfg_n < 1) return 1;
      if (cfg_n > cap) return cap;
      return int'(cfg_n);
   endfunction

   function automatic logic [CODED_W-1:0] trellis_step(input logic din, input int k,
                                                       input int n);
      logic [15:0]        mask;
      logic [15:0]        regv;
      logic [CODED_W-1:0] c;
      mask = (16'd1 << (k - 1)) - 16'd1;
      regv = ({15'd0, din} << (k - 1)) | ({8'd0, enc_state} & mask);
      c = '0;
      for (int j = 0; j < n; j++) begin
         c[j] = ^(regv & {7'd0, gens[j]});
      end
      enc_state = 8'((({8'd0, enc_state} & mask) >> 1) | ({15'd0, din} << (k - 2)));
      return c;
   endfunction

   function automatic void predict_groups(input logic [OP_W-1:0] op, input logic din,
                                          input logic fl, input logic [STATE_W-1:0] ns);
      int         k;
      int         n;
      logic [8:0] limit;
      group_type  g;
      k = eff_length();
      n = eff_width();
      limit = 9'd1 << (k - 1);
      g = '0;
      if (op == OP_LOAD) begin
         g.last = 1'b1;
         if ({1'b0, ns} >= limit) begin
            g.fault = 1'b1;
         end else begin
            enc_state = ns;
         end
         g.state = enc_state;
         coded_groups_due.push_back(g);
         return;
      end
      if (op != OP_ENCODE && op != OP_FLUSH) return;
      if ({1'b0, enc_state} >= limit) begin
         g.fault = 1'b1;
         g.last = 1'b1;
         g.state = enc_state;
         coded_groups_due.push_back(g);
         return;
      end
      if (op == OP_ENCODE) begin
         g.coded = trellis_step(din, k, n);
         g.last = !fl;
         g.state = enc_state;
         coded_groups_due.push_back(g);
         if (!fl) return;
      end
      for (int i = 0; i + 1 < k; i++) begin
         g = '0;
         g.coded = trellis_step(1'b0, k, n);
         g.last = (i + 2 == k);
         g.state = enc_state;
         coded_groups_due.push_back(g);
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [GEN_W-1:0] val);
      case (idx)
         CSR_CONSTRAINT: begin
            cfg_k = val[K_REG_W-1:0];
         end
         CSR_GEN_COUNT: begin
            cfg_n = val[N_W-1:0];
         end
         CSR_GEN_0, CSR_GEN_1, CSR_GEN_2, CSR_GEN_3, CSR_GEN_4: begin
            gens[int'(idx) - int'(CSR_GEN_0)] = val;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void queue_req(input logic [OP_W-1:0] op, input logic din,
                                     input logic fl, input logic [STATE_W-1:0] ns);
      request_type r;
      r.op = op;
      r.din = din;
      r.fl = fl;
      r.ns = ns;
      req_backlog.push_back(r);
   endfunction

   function automatic void queue_random_req();
      int               pick;
      logic [STATE_W-1:0] ns;
      logic [STATE_W-1:0] span;
      pick = $urandom_range(99);
      span = 8'((9'd1 << (eff_length() - 1)) - 9'd1);
      ns = 8'($urandom_range(255));
      if ($urandom_range(1) == 1) ns = ns & span;
      if (pick < 55) begin
         queue_req(OP_ENCODE, 1'($urandom_range(1)), 1'b0, ns);
      end else if (pick < 65) begin
         queue_req(OP_ENCODE, 1'($urandom_range(1)), 1'b1, ns);
      end else if (pick < 75) begin
         queue_req(OP_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1)), ns);
      end else if (pick < 94) begin
         queue_req(OP_LOAD, 1'($urandom_range(1)), 1'($urandom_range(1)), ns);
      end else begin
         queue_req(OP_RESERVED, 1'($urandom_range(1)), 1'($urandom_range(1)), ns);
      end
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_code(input logic [GEN_W-1:0] k, input logic [GEN_W-1:0] n,
                               input logic [GEN_W-1:0] g0, input logic [GEN_W-1:0] g1,
                               input logic [GEN_W-1:0] g2, input logic [GEN_W-1:0] g3,
                               input logic [GEN_W-1:0] g4);
      csr_write(CSR_CONSTRAINT, k);
      csr_write(CSR_GEN_COUNT, n);
      csr_write(CSR_GEN_0, g0);
      csr_write(CSR_GEN_1, g1);
      csr_write(CSR_GEN_2, g2);
      csr_write(CSR_GEN_3, g3);
      csr_write(CSR_GEN_4, g4);
      settings_run++;
   endtask

   // all requests out, all groups back, then let the pipeline drain
   task automatic settle();
      @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || coded_groups_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_groups(req_tuser, req_tdata[0], req_tlast, req_tdata[8:1]);
         requests_done++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.coded = rsp_tdata[CODED_W-1:0];
         got.state = rsp_tdata[CODED_W+STATE_W-1:CODED_W];
         got.fault = rsp_tuser;
         got.last = rsp_tlast;
         groups_seen++;
         if (got.fault) refused_seen++;
         if (coded_groups_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected group coded=%h err=%b last=%b state=%h", $time,
                     got.coded, got.fault, got.last, got.state);
         end else begin
            want = coded_groups_due.pop_front();
            if (got.coded !== want.coded || got.fault !== want.fault ||
                got.last !== want.last || got.state !== want.state) begin
               mismatches++;
               $display("%0t: expected %h/%b/%b/%h, actual %h/%b/%b/%h (coded/err/last/state)",
                        $time, want.coded, want.fault, want.last, want.state,
                        got.coded, got.fault, got.last, got.state);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.op;
            req_tlast <= nxt.fl;
            req_tdata <= {7'd0, nxt.ns, nxt.din};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= steady || ($urandom_range(99) >= 14);
   end

   initial begin
      #(2_000_000);
      $display("convolutional_encoder_core verification failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // reset code: K=7, 0171/0133
      queue_req(OP_ENCODE, 1'b1, 1'b0, 8'hff);
      queue_req(OP_ENCODE, 1'b0, 1'b0, 8'h00);
      queue_req(OP_ENCODE, 1'b1, 1'b1, 8'h5a);
      queue_req(OP_FLUSH, 1'b1, 1'b1, 8'hff);
      queue_req(OP_LOAD, 1'b0, 1'b0, 8'd63);
      queue_req(OP_ENCODE, 1'b0, 1'b1, 8'h00);
      queue_req(OP_LOAD, 1'b1, 1'b0, 8'd64);
      queue_req(OP_LOAD, 1'b0, 1'b1, 8'd255);
      queue_req(OP_RESERVED, 1'b1, 1'b1, 8'hff);
      queue_req(OP_ENCODE, 1'b1, 1'b0, 8'h00);
      settle();

      // widest code, then shrink K under a large state
      program_code(9'd9, 9'd5, 9'd511, 9'h155, 9'h0aa, 9'h1c3, 9'd256);
      queue_req(OP_LOAD, 1'b1, 1'b0, 8'd255);
      queue_req(OP_ENCODE, 1'b1, 1'b0, 8'h00);
      queue_req(OP_ENCODE, 1'b0, 1'b1, 8'hff);
      queue_req(OP_LOAD, 1'b0, 1'b0, 8'd200);
      settle();

      program_code(9'h1f3, 9'h1fb, 9'd7, 9'd5, 9'd3, 9'h1f8, 9'd6);
      queue_req(OP_ENCODE, 1'b1, 1'b0, 8'h00);
      queue_req(OP_FLUSH, 1'b0, 1'b0, 8'h00);
      queue_req(OP_LOAD, 1'b0, 1'b0, 8'd5);
      queue_req(OP_LOAD, 1'b1, 1'b0, 8'd3);
      queue_req(OP_ENCODE, 1'b1, 1'b1, 8'h00);
      settle();

      // K and n below range, plus a write to no register
      program_code(9'd0, 9'd0, 9'd3, 9'd1, 9'd2, 9'd0, 9'd0);
      csr_write(CSR_UNUSED, 9'h1ff);
      queue_req(OP_ENCODE, 1'b1, 1'b0, 8'h00);
      queue_req(OP_ENCODE, 1'b0, 1'b1, 8'h00);
      queue_req(OP_LOAD, 1'b1, 1'b0, 8'd2);
      settle();

      // K and n above range
      program_code(9'd15, 9'd7, 9'h1ed, 9'h0b7, 9'h133, 9'h0f1, 9'h19b);
      queue_req(OP_ENCODE, 1'b1, 1'b1, 8'h00);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         program_code(($urandom_range(7) == 0) ? 9'($urandom_range(511))
                                               : 9'($urandom_range(9, 2)),
                      ($urandom_range(7) == 0) ? 9'($urandom_range(511))
                                               : 9'($urandom_range(5, 1)),
                      9'($urandom_range(511)), 9'($urandom_range(511)),
                      9'($urandom_range(511)), 9'($urandom_range(511)),
                      9'($urandom_range(511)));
         steady = (phase == 2);
         for (int i = 0; i < 16; i++) begin
            queue_random_req();
         end
         settle();
         steady = 1'b0;
      end

      $display("%0d requests, %0d coded groups returned (%0d refused)",
               requests_done, groups_seen, refused_seen);
      $display("%0d register writes over %0d code settings", csr_writes, settings_run);
      if (mismatches == 0) begin
         $display("convolutional_encoder_core verification clean");
      end else begin
         $display("convolutional_encoder_core verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cec_pkg.sv
hdl/cec_step.sv
hdl/convolutional_encoder_core.sv
hdl/cec_checker.sv
sim/convolutional_encoder_core_test.sv
